/* hdl/crc8fr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Shared types and constants of the CRC-8 framed byte receiver.
// ----------------------------------------------------------------------------
package crc8fr_pkg;

    localparam int          CRC_W       = 8;
    localparam logic [7:0]  CRC_POLY    = 8'h07;
    localparam logic [7:0]  START_RESET = 8'hA5;

    // Frame parser position.
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN,
        PH_PAY,
        PH_CRC
    } phase_t;

    // Beat-level sequencer of the top level.
    typedef enum logic [1:0] {
        CTL_READY,
        CTL_CRC,
        CTL_READ,
        CTL_SEND
    } ctl_t;

    // Command to the bit-serial CRC unit.
    typedef struct packed {
        logic start;   // fold a new byte into the remainder and begin shifting
        logic clear;   // with start: begin from a zero remainder
    } crc_cmd_t;

endpackage

/* hdl/crc8fr_crc_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fr_crc_unit
// Bit-serial CRC-8 engine: folds one byte into the remainder, then shifts
// one bit per cycle until the byte is fully folded in.
// ----------------------------------------------------------------------------
module crc8fr_crc_unit (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  crc8fr_pkg::crc_cmd_t   cmd,
    input  logic [7:0]             data_in,
    output logic [7:0]             crc_out,
    output logic                   busy
);
    import crc8fr_pkg::*;

    localparam int          CNT_W    = $clog2(CRC_W);
    localparam logic [CNT_W-1:0] BIT_LAST = CNT_W'(CRC_W - 1);

    logic [7:0]       rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end else begin
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_comb begin
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (cmd.start) begin
            rem_next  = (cmd.clear ? 8'h00 : rem_reg) ^ data_in;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg[7]) begin
                rem_next = {rem_reg[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                rem_next = {rem_reg[6:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BIT_LAST) begin
                busy_next = 1'b0;
            end
        end
    end

    assign crc_out = rem_reg;
    assign busy    = busy_reg;

endmodule

/* hdl/crc8fr_payload_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fr_payload_ram
// Payload byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module crc8fr_payload_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);
    import crc8fr_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/crc8_frame_receiver_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_frame_receiver_unit
// Hunts for a start byte, parses type, length and payload, checks a CRC-8
// (poly 0x07, init 0) and emits the payload of good frames byte by byte.
// ----------------------------------------------------------------------------
// Channel    Dir  Beat contents
// s_axis     in   received byte
// m_axis     out  one payload byte of a good frame (or one empty marker)
// cfg        in   start byte value, written while idle
//
// Flow: a start-hunt byte, an oversize length byte or a CRC byte is taken
// without a CRC pass. A type, length or payload byte holds s_tready low
// while the bit-serial CRC unit shifts it in; the next beat is taken once
// the sequencer is back in ready. Each payload result is a payload RAM
// read, then the output beat, held while m_tready is low; the empty-frame
// marker skips the read. Input is not taken while results drain.
// Reset is synchronous; the payload RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module crc8_frame_receiver_unit #(
    parameter int  MAX_PAYLOAD = 16,
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1),
    localparam int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    localparam int M_TDATA_W   = ((8 + LEN_W + 8 + IDX_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,   // start_byte

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,       // rx_byte

    output logic                 m_tvalid,
    input  logic                 m_tready,
    // frame_type, payload_len, data_byte, byte_index (from bit 0 up), zero pad
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,       // has_data
    output logic                 m_tlast        // last
);
    import crc8fr_pkg::*;

    ctl_t             ctl_reg, ctl_next;
    phase_t           phase_reg, phase_next;
    logic [7:0]       start_byte_reg;
    logic [7:0]       type_reg, type_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             has_data_reg, has_data_next;

    crc_cmd_t         crc_cmd;
    logic [7:0]       crc_value;
    logic             crc_busy;
    logic             ram_we, ram_re;
    logic [7:0]       ram_rdata;
    logic [7:0]       data_byte;

    crc8fr_crc_unit u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (crc_cmd),
        .data_in (s_tdata),
        .crc_out (crc_value),
        .busy    (crc_busy)
    );

    crc8fr_payload_ram #(
        .DEPTH  (MAX_PAYLOAD),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (fill_reg[IDX_W-1:0]),
        .wr_data (s_tdata),
        .rd_en   (ram_re),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg <= START_RESET;
        end else if (cfg_wr_en) begin
            start_byte_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg      <= CTL_READY;
            phase_reg    <= PH_HUNT;
            type_reg     <= '0;
            len_reg      <= '0;
            fill_reg     <= '0;
            idx_reg      <= '0;
            has_data_reg <= 1'b0;
        end else begin
            ctl_reg      <= ctl_next;
            phase_reg    <= phase_next;
            type_reg     <= type_next;
            len_reg      <= len_next;
            fill_reg     <= fill_next;
            idx_reg      <= idx_next;
            has_data_reg <= has_data_next;
        end
    end

    assign m_tlast = !has_data_reg || ((LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);

    always_comb begin
        ctl_next      = ctl_reg;
        phase_next    = phase_reg;
        type_next     = type_reg;
        len_next      = len_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        has_data_next = has_data_reg;
        crc_cmd       = '0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        s_tready      = (ctl_reg == CTL_READY);
        m_tvalid      = (ctl_reg == CTL_SEND);

        case (ctl_reg)
            CTL_READY: begin
                if (s_tvalid) begin
                    case (phase_reg)
                        PH_TYPE: begin
                            type_next     = s_tdata;
                            crc_cmd.start = 1'b1;
                            crc_cmd.clear = 1'b1;
                            phase_next    = PH_LEN;
                            ctl_next      = CTL_CRC;
                        end
                        PH_LEN: begin
                            // An oversize length drops the frame; the next byte
                            // is only tested as a start byte after this one.
                            if (s_tdata > 8'(MAX_PAYLOAD)) begin
                                phase_next = PH_HUNT;
                            end else begin
                                len_next      = s_tdata[LEN_W-1:0];
                                fill_next     = '0;
                                crc_cmd.start = 1'b1;
                                ctl_next      = CTL_CRC;
                                phase_next    = (s_tdata == 8'h00) ? PH_CRC : PH_PAY;
                            end
                        end
                        PH_PAY: begin
                            ram_we        = 1'b1;
                            fill_next     = fill_reg + 1'b1;
                            crc_cmd.start = 1'b1;
                            ctl_next      = CTL_CRC;
                            if (fill_next == len_reg) begin
                                phase_next = PH_CRC;
                            end
                        end
                        PH_CRC: begin
                            phase_next = PH_HUNT;
                            if (crc_value == s_tdata) begin
                                idx_next = '0;
                                if (len_reg == '0) begin
                                    has_data_next = 1'b0;
                                    ctl_next      = CTL_SEND;
                                end else begin
                                    has_data_next = 1'b1;
                                    ctl_next      = CTL_READ;
                                end
                            end
                        end
                        default: begin
                            phase_next = (s_tdata == start_byte_reg) ? PH_TYPE : PH_HUNT;
                        end
                    endcase
                end
            end
            CTL_CRC: begin
                if (!crc_busy) begin
                    ctl_next = CTL_READY;
                end
            end
            CTL_READ: begin
                ram_re   = 1'b1;
                ctl_next = CTL_SEND;
            end
            CTL_SEND: begin
                if (m_tready) begin
                    if (m_tlast) begin
                        ctl_next = CTL_READY;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        ctl_next = CTL_READ;
                    end
                end
            end
            default: begin
                ctl_next = CTL_READY;
            end
        endcase
    end

    // The empty-frame marker carries a zero data byte.
    assign data_byte = has_data_reg ? ram_rdata : 8'h00;
    assign m_tdata   = M_TDATA_W'({idx_reg, data_byte, len_reg, type_reg});
    assign m_tuser   = has_data_reg;

    a_no_input_while_sending: assert property (
        @(posedge aclk) disable iff (!aresetn) m_tvalid |-> !s_tready
    ) else $error("input taken while a result beat is pending");

    a_no_input_while_crc: assert property (
        @(posedge aclk) disable iff (!aresetn) crc_busy |-> !s_tready
    ) else $error("input taken while the CRC unit is shifting");

    a_ready_after_last: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready
    ) else $error("receiver not ready after the last beat of a frame");

    a_index_in_frame: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (LEN_W'(idx_reg) < len_reg)
    ) else $error("payload index beyond frame length");

endmodule

/* test/crc8fr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8fr_checker
// Watches the byte input, the start byte write and the result channel of the
// CRC-8 frame receiver. It keeps its own copy of the parser state, works out
// the result beats of every accepted byte and compares each result beat field
// by field with the oldest one still due.
// ----------------------------------------------------------------------------
package crc8fr_tb_pkg;

    // One step of CRC-8, MSB first, with no final xor.
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        int         i;
        r = crc ^ b;
        for (i = 0; i < 8; i++) begin
            r = r[7] ? ((r << 1) ^ crc8fr_pkg::CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

endpackage

module crc8fr_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    import crc8fr_pkg::*;
    import crc8fr_tb_pkg::*;

    localparam int MAX_PAYLOAD = 16;

    typedef struct packed {
        logic [7:0] frame_type;
        logic [4:0] payload_len;
        logic       has_data;
        logic [7:0] data_byte;
        logic [3:0] byte_index;
        logic       is_last;
    } rx_result_t;

    phase_t     phase;
    logic [7:0] start_value;
    logic [7:0] held_type;
    logic [4:0] held_len;
    logic [4:0] fill_count;
    logic [7:0] running_crc;
    logic [7:0] payload_mem [MAX_PAYLOAD];
    rx_result_t results_due [$];

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic push_result(input logic [7:0] data, input logic has, input int idx,
                               input logic lst);
        rx_result_t r;
        r.frame_type  = held_type;
        r.payload_len = held_len;
        r.has_data    = has;
        r.data_byte   = data;
        r.byte_index  = idx[3:0];
        r.is_last     = lst;
        results_due.push_back(r);
    endtask

    // Advances the parser by one received byte and queues the results it releases.
    task automatic parse_rx_byte(input logic [7:0] b);
        int i;
        case (phase)
            PH_TYPE: begin
                held_type   = b;
                running_crc = crc8_fold(8'h00, b);
                phase       = PH_LEN;
            end
            PH_LEN: begin
                if (b > MAX_PAYLOAD) begin
                    phase = PH_HUNT;
                end else begin
                    held_len    = b[4:0];
                    fill_count  = 5'd0;
                    running_crc = crc8_fold(running_crc, b);
                    phase       = (b == 8'h00) ? PH_CRC : PH_PAY;
                end
            end
            PH_PAY: begin
                payload_mem[fill_count[3:0]] = b;
                fill_count  = fill_count + 5'd1;
                running_crc = crc8_fold(running_crc, b);
                if (fill_count >= held_len) begin
                    phase = PH_CRC;
                end
            end
            PH_CRC: begin
                if (running_crc == b) begin
                    if (held_len == 5'd0) begin
                        push_result(8'h00, 1'b0, 0, 1'b1);
                    end else begin
                        for (i = 0; i < held_len; i++) begin
                            push_result(payload_mem[i], 1'b1, i, (i + 1 == held_len));
                        end
                    end
                end
                phase = PH_HUNT;
            end
            default: begin
                phase = (b == start_value) ? PH_TYPE : PH_HUNT;
            end
        endcase
    endtask

    always @(posedge aclk) begin
        rx_result_t want;
        if (!aresetn) begin
            phase       = PH_HUNT;
            start_value = START_RESET;
            held_type   = 8'h00;
            held_len    = 5'd0;
            fill_count  = 5'd0;
            running_crc = 8'h00;
            results_due.delete();
        end else begin
            if (m_tvalid === 1'b1 && m_tready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result beat with nothing due, tdata", m_tdata, 0);
                end else begin
                    want = results_due.pop_front();
                    check_field("frame_type", m_tdata[7:0], want.frame_type);
                    check_field("payload_len", m_tdata[12:8], want.payload_len);
                    check_field("data_byte", m_tdata[20:13], want.data_byte);
                    check_field("byte_index", m_tdata[24:21], want.byte_index);
                    check_field("tdata padding", m_tdata[31:25], 0);
                    check_field("has_data", m_tuser, want.has_data);
                    check_field("last", m_tlast, want.is_last);
                end
            end
            if (cfg_wr_en) begin
                start_value = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                parse_rx_byte(s_tdata);
            end
        end
        pending = results_due.size();
    end

endmodule

/* test/crc8_frame_receiver_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc8_frame_receiver_unit_tb
// Drives received bytes into the CRC-8 frame receiver: a short directed run
// over the special cases, then random well-formed, corrupted, oversized and
// truncated frames mixed with noise, under four start byte settings. Both
// channels idle at random; the checker beside the block judges every beat.
// ----------------------------------------------------------------------------
module crc8_frame_receiver_unit_tb;
    import crc8fr_pkg::*;
    import crc8fr_tb_pkg::*;

    localparam int MAX_PAYLOAD     = 16;
    localparam int SETTLE_CYCLES   = 30;
    localparam int BYTES_PER_PHASE = 72;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;       // frame_type, payload_len, data_byte, byte_index, zero pad
    logic        m_tuser;       // has_data
    logic        m_tlast;       // last
    int          fail_count;
    int          pending;

    bit          s_gappy;
    int          bytes_sent;
    logic [7:0]  pay_buf [MAX_PAYLOAD];

    crc8_frame_receiver_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    crc8fr_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Result-side back-pressure: long open stretches, short stalls and a few long ones.
    initial begin
        int   hold;
        int   r;
        logic lvl;
        m_tready = 1'b0;
        forever begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                lvl  = 1'b1;
                hold = $urandom_range(30, 150);
            end else if (r < 15) begin
                lvl  = 1'b0;
                hold = $urandom_range(10, 40);
            end else if (r < 45) begin
                lvl  = 1'b0;
                hold = $urandom_range(1, 3);
            end else begin
                lvl  = 1'b1;
                hold = $urandom_range(1, 6);
            end
            @(negedge aclk);
            m_tready <= lvl;
            repeat (hold - 1) @(negedge aclk);
        end
    end

    function automatic int pick_gap();
        int r;
        if (!s_gappy) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return MAX_PAYLOAD;
        end
        if (r == 1) begin
            return 0;
        end
        return $urandom_range(1, 6);
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    // tvalid stays high on return, so the caller drives the next beat or lowers it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // Sends a whole frame with the payload taken from pay_buf.
    task automatic send_frame(input logic [7:0] sb, input logic [7:0] ftype, input int len,
                              input bit corrupt);
        logic [7:0] crc;
        int         i;
        crc = crc8_fold(crc8_fold(8'h00, ftype), len[7:0]);
        send_byte(sb);
        send_byte(ftype);
        send_byte(len[7:0]);
        for (i = 0; i < len; i++) begin
            send_byte(pay_buf[i]);
            crc = crc8_fold(crc, pay_buf[i]);
        end
        if (corrupt) begin
            crc = crc ^ (8'h01 << $urandom_range(0, 7));
        end
        send_byte(crc);
    endtask

    task automatic write_start(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Holds the sender off until every result is out and the parser has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic random_phase(input logic [7:0] sb, input int nbytes);
        int stop_at;
        int kind;
        int len;
        int i;
        stop_at = bytes_sent + nbytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 4) == 0) begin
                s_gappy = ~s_gappy;
            end
            for (i = 0; i < MAX_PAYLOAD; i++) begin
                pay_buf[i] = 8'($urandom);
            end
            kind = $urandom_range(0, 99);
            len  = pick_len();
            if (kind < 68) begin
                send_frame(sb, 8'($urandom), len, 1'b0);
            end else if (kind < 78) begin
                send_frame(sb, 8'($urandom), len, 1'b1);
            end else if (kind < 86) begin
                send_byte(sb);
                send_byte(8'($urandom));
                send_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
            end else if (kind < 93) begin
                // The header promises more payload than follows, so the next
                // frame's bytes are swallowed as payload.
                len = $urandom_range(2, MAX_PAYLOAD);
                send_byte(sb);
                send_byte(8'($urandom));
                send_byte(len[7:0]);
                repeat ($urandom_range(0, len - 1)) send_byte(8'($urandom));
            end else begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        logic [7:0] sb;
        int         ph;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 8'h00;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_gappy     = 1'b0;
        bytes_sent  = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        write_start(START_RESET);

        // Directed: noise, empty frame, oversized lengths, bad CRC, extreme data.
        send_byte(8'h00);
        send_frame(START_RESET, 8'hFF, 0, 1'b0);
        send_byte(START_RESET);
        send_byte(8'h5A);
        send_byte(8'hFF);
        send_byte(START_RESET);
        send_byte(8'h01);
        send_byte(8'h11);
        pay_buf[0] = 8'h80;
        pay_buf[1] = 8'h7F;
        pay_buf[2] = 8'h01;
        send_frame(START_RESET, 8'h01, 3, 1'b1);
        pay_buf[0] = 8'h00;
        pay_buf[1] = 8'hFF;
        send_frame(START_RESET, 8'h00, 2, 1'b0);
        settle();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       sb = START_RESET;
                1:       sb = 8'h00;
                2:       sb = 8'hFF;
                default: sb = 8'($urandom);
            endcase
            if (ph != 0) begin
                write_start(sb);
            end
            s_gappy = (ph % 2 == 1);
            random_phase(sb, BYTES_PER_PHASE);
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/crc8fr_pkg.sv
hdl/crc8fr_crc_unit.sv
hdl/crc8fr_payload_ram.sv
hdl/crc8_frame_receiver_unit.sv
test/crc8fr_checker.sv
test/crc8_frame_receiver_unit_tb.sv
